// ----- src/pcl_pkg.sv -----
package pcl_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W    = $clog2(CAPACITY + 1);

    localparam int REQ_W    = 2;
    localparam int POS_W    = 7;
    localparam int CHAR_W   = 8;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 7;

    // common width for position versus length arithmetic
    localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

    localparam logic [REQ_W-1:0] REQ_INSERT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_LAST = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REVERSE  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOPOS = 2'd3;

    typedef logic [1:0] cell_op_t;
    localparam cell_op_t OP_HOLD = 2'd0;
    localparam cell_op_t OP_INS  = 2'd1;
    localparam cell_op_t OP_DEL  = 2'd2;

    // command broadcast to every cell of the row
    typedef struct packed {
        cell_op_t            op;
        logic [IDX_W-1:0]    sel;
        logic [CHAR_W-1:0]   din;
    } cell_cmd_t;

endpackage

// ----- src/positional_char_list.sv -----
// Bounded ordered byte list held in a row of CAPACITY cells, one byte per cell. Each request
// is registered when taken and executed in the next cycle; no new request is accepted while
// one executes, and a stalled result holds off the next request. Insert and remove shift
// the affected cells by one place toward their neighbor. Reverse only flips an orientation
// bit that remaps positions onto cells. Every request returns one result transfer with the
// removed byte, a status and the new length. No clearing pass follows reset; the list is
// empty and ready right away.
module positional_char_list
    import pcl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // position[6:0], char_in[14:7], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // char_out[7:0], count[14:8], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic               state_reg, state_next;
    logic [REQ_W-1:0]   req_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               rev_reg, rev_next;

    logic               m_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [STAT_W-1:0]  out_stat_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               s_xfer;
    logic               m_xfer;

    cell_cmd_t          cmd;
    logic [STAT_W-1:0]  status;
    logic [CHAR_W-1:0]  removed;
    logic [CHAR_W-1:0]  char_out;

    logic [CMP_W-1:0]   posx;
    logic [CMP_W-1:0]   lenx;
    logic [CMP_W-1:0]   at;
    logic [CMP_W-1:0]   phys;

    logic [CHAR_W-1:0]  cell_data [CAPACITY];
    logic [CHAR_W-1:0]  cell_tap  [CAPACITY];

    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_valid_reg && m_tready;
    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);

    assign posx = CMP_W'(pos_reg);
    assign lenx = CMP_W'(len_reg);

    // decode the held request against the current length and orientation
    always_comb begin
        cmd.op   = OP_HOLD;
        cmd.din  = char_reg;
        phys     = '0;
        at       = '0;
        status   = STAT_OK;
        len_next = len_reg;
        rev_next = rev_reg;
        if (state_reg == S_EXEC) begin
            case (req_reg)
                REQ_INSERT: begin
                    at = (posx <= CMP_W'(1)) ? '0 : posx - CMP_W'(1);
                    if (at > lenx) begin
                        at = lenx;
                    end
                    if (lenx >= CMP_W'(CAPACITY)) begin
                        status = STAT_FULL;
                    end else begin
                        cmd.op   = OP_INS;
                        phys     = rev_reg ? (lenx - at) : at;
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                REQ_REMOVE: begin
                    if (len_reg == '0) begin
                        status = STAT_EMPTY;
                    end else if (posx == '0 || posx > lenx) begin
                        status = STAT_NOPOS;
                    end else begin
                        cmd.op   = OP_DEL;
                        phys     = rev_reg ? (lenx - posx) : (posx - CMP_W'(1));
                        len_next = len_reg - LEN_W'(1);
                    end
                end
                REQ_POP_LAST: begin
                    if (len_reg == '0) begin
                        status = STAT_EMPTY;
                    end else begin
                        cmd.op   = OP_DEL;
                        phys     = rev_reg ? '0 : (lenx - CMP_W'(1));
                        len_next = len_reg - LEN_W'(1);
                    end
                end
                REQ_REVERSE: begin
                    rev_next = ~rev_reg;
                end
                default: begin
                    status = STAT_OK;
                end
            endcase
        end
        cmd.sel = phys[IDX_W-1:0];
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [CHAR_W-1:0] left_d;
            logic [CHAR_W-1:0] right_d;
            if (gi == 0) begin : g_first
                assign left_d = '0;
            end else begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_d = '0;
            end else begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end
            pcl_cell u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .cell_idx   (IDX_W'(gi)),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .tap        (cell_tap[gi])
            );
        end
    endgenerate

    always_comb begin
        removed = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            removed = removed | cell_tap[i];
        end
    end

    assign char_out   = (cmd.op == OP_DEL) ? removed : '0;
    assign state_next = s_xfer ? S_EXEC : S_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            rev_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            rev_reg   <= rev_next;
            if (state_reg == S_EXEC) begin
                m_valid_reg <= 1'b1;
            end else if (m_xfer) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_reg  <= s_tuser;
            pos_reg  <= s_tdata[6:0];
            char_reg <= s_tdata[14:7];
        end
        if (state_reg == S_EXEC) begin
            out_char_reg  <= char_out;
            out_stat_reg  <= status;
            out_count_reg <= COUNT_W'(len_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_char_reg};
    assign m_tuser  = out_stat_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lenx <= CMP_W'(CAPACITY))
        else $error("length exceeds capacity");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |=> m_valid_reg)
        else $error("executed request produced no result");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_stat_reg == STAT_FULL) |-> (out_count_reg == COUNT_W'(CAPACITY)))
        else $error("full status with list not full");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_stat_reg == STAT_EMPTY) |-> (out_count_reg == '0))
        else $error("empty status with nonzero length");

endmodule

// ----- src/pcl_cell.sv -----
module pcl_cell
    import pcl_pkg::*;
(
    input  logic              aclk,
    input  cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]  cell_idx,
    input  logic [CHAR_W-1:0] left_data,
    input  logic [CHAR_W-1:0] right_data,
    output logic [CHAR_W-1:0] data,
    output logic [CHAR_W-1:0] tap
);

    logic [CHAR_W-1:0] data_reg;
    logic [CHAR_W-1:0] data_next;
    logic              hit;
    logic              above;

    assign hit   = (cell_idx == cmd.sel);
    assign above = (cell_idx > cmd.sel);

    always_comb begin
        data_next = data_reg;
        case (cmd.op)
            OP_INS: begin
                if (hit) begin
                    data_next = cmd.din;
                end else if (above) begin
                    data_next = left_data;
                end
            end
            OP_DEL: begin
                if (hit || above) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // selected cell drives its byte onto the or-tree
    assign tap  = hit ? data_reg : '0;

endmodule
